FILE: hdl/dfa_pkg.sv
package dfa_pkg;

    localparam int LEN_W   = 10;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT     = 2'd2;

    localparam logic [LEN_W-1:0]  RST_MAX_FRAME_LEN   = 10'd128;
    localparam logic [TIME_W-1:0] RST_BURST_WINDOW_MS = 32'd1000;
    localparam logic [CNT_W-1:0]  RST_BURST_LIMIT     = 8'd5;

    localparam logic [BYTE_W-1:0] CH_START = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_END   = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;
    localparam logic [CNT_W-1:0]  COUNT_SAT = 8'd255;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } dfa_res_t;

    typedef struct packed {
        logic clear;
        logic malformed;
    } dfa_evt_t;

endpackage

FILE: hdl/dfa_frame.sv
module dfa_frame (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic                         op,
    input  logic [dfa_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [dfa_pkg::LEN_W-1:0]    max_frame_len,
    output dfa_pkg::dfa_res_t            res,
    output dfa_pkg::dfa_evt_t            evt
);
    import dfa_pkg::*;

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             printable;

    assign printable = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);

    always_comb begin
        res           = '0;
        evt           = '0;
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        if (op == OP_CLEAR) begin
            evt.clear = 1'b1;
        end else if (rx_byte == CH_START) begin
            in_frame_next = 1'b1;
            count_next    = '0;
            if (in_frame_reg) begin
                res.valid = 1'b1;
                res.kind  = KIND_ABORT;
            end
        end else if (!in_frame_reg) begin
            in_frame_next = 1'b0;
        end else if (rx_byte == CH_END) begin
            in_frame_next = 1'b0;
            count_next    = '0;
            res.valid     = 1'b1;
            res.kind      = KIND_DONE;
            res.len       = count_reg;
        end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
            in_frame_next = 1'b1;
        end else if (count_reg >= max_frame_len || !printable) begin
            in_frame_next = 1'b0;
            count_next    = '0;
            evt.malformed = 1'b1;
            res.valid     = 1'b1;
            res.kind      = KIND_ABORT;
        end else begin
            count_next = count_reg + LEN_W'(1);
            res.valid  = 1'b1;
            res.kind   = KIND_PAYLOAD;
            res.data   = rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end else if (fire) begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

endmodule

FILE: hdl/dfa_burst.sv
module dfa_burst (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  dfa_pkg::dfa_evt_t           evt,
    input  logic [dfa_pkg::TIME_W-1:0]  now_ms,
    input  logic [dfa_pkg::TIME_W-1:0]  burst_window_ms,
    input  logic [dfa_pkg::CNT_W-1:0]   burst_limit,
    output logic                        recovery
);
    import dfa_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic [TIME_W-1:0] elapsed;
    logic              reopen;
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  bumped;
    logic              hit;

    assign elapsed = now_ms - start_reg;
    assign reopen  = (start_reg == '0) || (elapsed > burst_window_ms);
    assign base    = reopen ? '0 : count_reg;
    assign bumped  = (base == COUNT_SAT) ? COUNT_SAT : base + CNT_W'(1);
    assign hit     = bumped >= burst_limit;
    assign recovery = evt.malformed && hit;

    always_comb begin
        count_next = count_reg;
        start_next = start_reg;
        if (evt.clear) begin
            count_next = '0;
            start_next = '0;
        end else if (evt.malformed) begin
            if (hit) begin
                count_next = '0;
                start_next = '0;
            end else begin
                count_next = bumped;
                start_next = reopen ? now_ms : start_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            start_reg <= '0;
        end else if (fire) begin
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

endmodule

FILE: hdl/delimited_frame_assembler.sv
// An accepted input transaction waits in an input register; its result is registered in a result
// register when that is free. Throughput: one item per cycle while m_tready does not hold results back;
// the two registers decouple the two sides, so a new item is taken while a finished result still waits.
// Reset (aresetn, synchronous, active low) leaves no frame open, no burst open and
// the configuration registers at their documented defaults.
module delimited_frame_assembler (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rx_byte [7:0], now_ms [39:8]
    input  logic [dfa_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // data_byte [7:0], frame_length [17:8], recovery_request [18], zero fill above
    output logic [dfa_pkg::M_TDATA_W-1:0]    m_tdata,
    // kind [1:0]
    output logic [dfa_pkg::KIND_W-1:0]       m_tuser,
    input  logic                             cfg_we,
    input  logic [dfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import dfa_pkg::*;

    logic [LEN_W-1:0]  max_frame_len_reg;
    logic [TIME_W-1:0] burst_window_reg;
    logic [CNT_W-1:0]  burst_limit_reg;

    logic              in_valid_reg;
    logic              in_op_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [TIME_W-1:0] in_now_reg;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_rec_reg;

    logic              proc_fire;
    logic              in_take;
    dfa_res_t          res;
    dfa_evt_t          evt;
    logic              recovery;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_len_reg <= RST_MAX_FRAME_LEN;
            burst_window_reg  <= RST_BURST_WINDOW_MS;
            burst_limit_reg   <= RST_BURST_LIMIT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_FRAME_LEN:   max_frame_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_BURST_WINDOW_MS: burst_window_reg  <= cfg_wdata[TIME_W-1:0];
                REG_BURST_LIMIT:     burst_limit_reg   <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_now_reg  <= s_tdata[BYTE_W+TIME_W-1:BYTE_W];
        end
    end

    dfa_frame u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (proc_fire),
        .op            (in_op_reg),
        .rx_byte       (in_byte_reg),
        .max_frame_len (max_frame_len_reg),
        .res           (res),
        .evt           (evt)
    );

    dfa_burst u_burst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (proc_fire),
        .evt             (evt),
        .now_ms          (in_now_reg),
        .burst_window_ms (burst_window_reg),
        .burst_limit     (burst_limit_reg),
        .recovery        (recovery)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            out_kind_reg <= res.kind;
            out_data_reg <= res.data;
            out_len_reg  <= res.len;
            out_rec_reg  <= recovery;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {(M_TDATA_W-BYTE_W-LEN_W-1)'(0), out_rec_reg, out_len_reg, out_data_reg};

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc_fire |=> in_valid_reg)
        else $error("Held input transaction was dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_rec_reg |-> out_kind_reg == KIND_ABORT)
        else $error("Recovery request on a result that is not an abort");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != KIND_DONE |-> out_len_reg == '0)
        else $error("Frame length set on a result that is not a completion");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != KIND_PAYLOAD |-> out_data_reg == '0)
        else $error("Data byte set on a result that is not a payload byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg == KIND_PAYLOAD |->
        out_data_reg >= PRINT_LO && out_data_reg <= PRINT_HI)
        else $error("Non-printable byte passed on as payload");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfa_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_ITEMS = 60;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              recover;
    } frame_event_t;

    class frame_scoreboard;
        logic [LEN_W-1:0]  max_len;
        logic [TIME_W-1:0] window_ms;
        logic [CNT_W-1:0]  limit;
        logic              in_frame;
        logic [LEN_W-1:0]  count;
        logic [CNT_W-1:0]  burst_count;
        logic [TIME_W-1:0] burst_start;
        frame_event_t      expected_events[$];
        int                errors;

        function new();
            max_len = RST_MAX_FRAME_LEN;
            window_ms = RST_BURST_WINDOW_MS;
            limit = RST_BURST_LIMIT;
            in_frame = 1'b0;
            count = '0;
            burst_count = '0;
            burst_start = '0;
            errors = 0;
        endfunction

        function void add_event(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                                input logic [LEN_W-1:0] len, input logic recover);
            frame_event_t ev;
            ev.kind = kind;
            ev.data = data;
            ev.len = len;
            ev.recover = recover;
            expected_events.push_back(ev);
        endfunction

        // A burst is reopened when none is open or the window has run out.
        function logic count_malformed(input logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            elapsed = now - burst_start;
            if (burst_start == '0 || elapsed > window_ms) begin
                burst_start = now;
                burst_count = '0;
            end
            if (burst_count < COUNT_SAT)
                burst_count = burst_count + 1'b1;
            if (burst_count >= limit) begin
                burst_count = '0;
                burst_start = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(input logic op, input logic [BYTE_W-1:0] c,
                                input logic [TIME_W-1:0] now);
            logic was_open;
            logic recover;
            if (op == OP_CLEAR) begin
                burst_count = '0;
                burst_start = '0;
                return;
            end
            if (c == CH_START) begin
                was_open = in_frame;
                in_frame = 1'b1;
                count = '0;
                if (was_open)
                    add_event(KIND_ABORT, '0, '0, 1'b0);
                return;
            end
            if (!in_frame)
                return;
            if (c == CH_END) begin
                add_event(KIND_DONE, '0, count, 1'b0);
                in_frame = 1'b0;
                count = '0;
                return;
            end
            if (c == CH_CR || c == CH_LF)
                return;
            if (count >= max_len || c < PRINT_LO || c > PRINT_HI) begin
                in_frame = 1'b0;
                count = '0;
                recover = count_malformed(now);
                add_event(KIND_ABORT, '0, '0, recover);
                return;
            end
            count = count + 1'b1;
            add_event(KIND_PAYLOAD, c, '0, 1'b0);
        endfunction

        function void check_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                                   input logic [LEN_W-1:0] len, input logic recover);
            frame_event_t want;
            if (expected_events.size() == 0) begin
                $error("unexpected result transaction: kind %0d data %0h length %0d",
                       kind, data, len);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $error("data_byte: expected %0h, got %0h", want.data, data);
                errors++;
            end
            if (len !== want.len) begin
                $error("frame_length: expected %0d, got %0d", want.len, len);
                errors++;
            end
            if (recover !== want.recover) begin
                $error("recovery_request: expected %0b, got %0b", want.recover, recover);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    frame_scoreboard  tracker = new();
    logic [TIME_W-1:0] stamp_ms = '0;
    logic [LEN_W-1:0]  cur_max_len = RST_MAX_FRAME_LEN;
    int                burst_left = 0;
    bit                steady_sender = 1'b0;
    int                random_sent = 0;
    int                quiet_cycles = 0;
    int                rx_tick = 0;
    int                stall_mode = 0;
    logic [12:0]       stall_pattern = 13'b1011001110001;

    delimited_frame_assembler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 200 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_tready <= stall_pattern[rx_tick % 13];
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tuser, m_tdata[7:0], m_tdata[17:8], m_tdata[18]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function void advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            stamp_ms = stamp_ms + $urandom_range(0, 3);
        else if (r < 92)
            stamp_ms = stamp_ms + $urandom_range(4, 60);
        else if (r < 97)
            stamp_ms = $urandom;
        else if (r < 99)
            stamp_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else
            stamp_ms = '0;
    endfunction

    function logic [BYTE_W-1:0] printable_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(PRINT_LO, PRINT_HI));
        if (b == CH_START || b == CH_END)
            b = 8'h5A;
        return b;
    endfunction

    function logic [BYTE_W-1:0] bad_byte();
        logic [BYTE_W-1:0] b;
        b = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 31))
                                 : BYTE_W'($urandom_range(127, 255));
        if (b == CH_CR || b == CH_LF)
            b = 8'h1B;
        return b;
    endfunction

    // The sender runs in bursts; a new burst may begin after a gap.
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] c,
                             input logic [TIME_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {t, c};
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(op, c, t);
    endtask

    task automatic push_item(input logic op, input logic [BYTE_W-1:0] c);
        advance_clock();
        send_item(op, c, stamp_ms);
        random_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.expected_events.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_config(input logic [LEN_W-1:0] max_len,
                                input logic [TIME_W-1:0] window_ms,
                                input logic [CNT_W-1:0] limit);
        cfg_we <= 1'b1;
        cfg_index <= REG_MAX_FRAME_LEN;
        cfg_wdata <= CFG_DATA_W'(max_len);
        @(posedge aclk);
        tracker.max_len = max_len;
        cfg_index <= REG_BURST_WINDOW_MS;
        cfg_wdata <= window_ms;
        @(posedge aclk);
        tracker.window_ms = window_ms;
        cfg_index <= REG_BURST_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(posedge aclk);
        tracker.limit = limit;
        cfg_we <= 1'b0;
        cur_max_len = max_len;
    endtask

    // Mostly good frames; some are cut short by a bad byte, a restart or an overlong payload.
    task automatic send_frame();
        int i;
        int r;
        int plen;
        int bad_at;
        bit overflow;
        bit malformed;
        bit restart;
        r = $urandom_range(0, 99);
        overflow = (r < 10) && (cur_max_len <= 24);
        malformed = (r >= 10 && r < 22);
        restart = (r >= 22 && r < 28);
        plen = $urandom_range(0, (cur_max_len < 24) ? cur_max_len : 24);
        if (overflow)
            plen = cur_max_len + 1;
        bad_at = $urandom_range(0, plen);
        push_item(OP_RECEIVE, CH_START);
        for (i = 0; i < plen; i++) begin
            if (malformed && i == bad_at) begin
                push_item(OP_RECEIVE, bad_byte());
                return;
            end
            if (restart && i == bad_at)
                push_item(OP_RECEIVE, CH_START);
            if ($urandom_range(0, 9) == 0)
                push_item(OP_RECEIVE, $urandom_range(0, 1) ? CH_CR : CH_LF);
            push_item(OP_RECEIVE, printable_byte());
        end
        if (overflow)
            return;
        if (malformed) begin
            push_item(OP_RECEIVE, bad_byte());
            return;
        end
        push_item(OP_RECEIVE, CH_END);
    endtask

    task automatic run_phase(input int n);
        int target;
        int r;
        target = random_sent + n;
        while (random_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_frame();
            end else if (r < 85) begin
                push_item(OP_RECEIVE, BYTE_W'($urandom_range(0, 255)));
            end else if (r < 92) begin
                push_item(OP_CLEAR, BYTE_W'($urandom_range(0, 255)));
            end else if (r < 98) begin
                repeat ($urandom_range(1, 6)) begin
                    push_item(OP_RECEIVE, CH_START);
                    push_item(OP_RECEIVE, bad_byte());
                end
            end else begin
                wait_drained();
            end
        end
    endtask

    initial begin
        int phase;
        logic [LEN_W-1:0]  cfg_len;
        logic [TIME_W-1:0] cfg_window;
        logic [CNT_W-1:0]  cfg_limit;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_RECEIVE;
        cfg_we <= 1'b0;
        cfg_index <= REG_MAX_FRAME_LEN;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Bytes outside a frame are ignored, including a stray frame end.
        send_item(OP_RECEIVE, 8'h00, 32'd0);
        send_item(OP_RECEIVE, 8'hFF, 32'd1);
        send_item(OP_RECEIVE, 8'h41, 32'd2);
        send_item(OP_RECEIVE, CH_END, 32'd3);
        send_item(OP_RECEIVE, CH_CR, 32'd4);
        // Printable limits pass through, line endings are dropped.
        send_item(OP_RECEIVE, CH_START, 32'd10);
        send_item(OP_RECEIVE, 8'h41, 32'd11);
        send_item(OP_RECEIVE, PRINT_LO, 32'd12);
        send_item(OP_RECEIVE, PRINT_HI, 32'd13);
        send_item(OP_RECEIVE, CH_CR, 32'd14);
        send_item(OP_RECEIVE, CH_LF, 32'd15);
        send_item(OP_RECEIVE, CH_END, 32'd16);
        send_item(OP_RECEIVE, CH_START, 32'd17);
        send_item(OP_RECEIVE, CH_END, 32'd18);
        // A restart inside a frame aborts without counting as malformed.
        send_item(OP_RECEIVE, CH_START, 32'd19);
        send_item(OP_RECEIVE, 8'h78, 32'd20);
        send_item(OP_RECEIVE, CH_START, 32'd21);
        // A rejection at time zero leaves the burst looking closed.
        send_item(OP_RECEIVE, 8'h1F, 32'd0);
        send_item(OP_RECEIVE, CH_START, 32'd5);
        send_item(OP_RECEIVE, 8'h7F, 32'd5);
        send_item(OP_RECEIVE, CH_START, 32'd6);
        send_item(OP_RECEIVE, 8'hFF, 32'd6);
        send_item(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        send_item(OP_RECEIVE, CH_START, 32'hFFFF_FFFF);
        send_item(OP_RECEIVE, 8'h61, 32'hFFFF_FFFF);
        send_item(OP_RECEIVE, CH_END, 32'hFFFF_FFFF);

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drained();
            case (phase)
                0: begin
                    cfg_len = 10'd1;
                    cfg_window = 32'hFFFF_FFFF;
                    cfg_limit = 8'd1;
                end
                1: begin
                    cfg_len = 10'd0;
                    cfg_window = 32'd0;
                    cfg_limit = 8'd0;
                end
                2: begin
                    cfg_len = 10'd1023;
                    cfg_window = 32'd1;
                    cfg_limit = 8'd255;
                end
                3: begin
                    cfg_len = 10'd24;
                    cfg_window = 32'd3;
                    cfg_limit = 8'd3;
                end
                default: begin
                    cfg_len = LEN_W'($urandom_range(1, 24));
                    cfg_window = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40);
                    cfg_limit = ($urandom_range(0, 7) == 0) ? 8'd255
                                                            : CNT_W'($urandom_range(1, 6));
                end
            endcase
            write_config(cfg_len, cfg_window, cfg_limit);
            steady_sender = ($urandom_range(0, 3) == 0);
            if (cfg_len == 10'd1023) begin
                advance_clock();
                send_item(OP_RECEIVE, CH_START, stamp_ms);
                repeat (1023) send_item(OP_RECEIVE, printable_byte(), stamp_ms);
                send_item(OP_RECEIVE, CH_END, stamp_ms);
            end
            run_phase(PHASE_ITEMS);
            phase++;
        end

        s_tvalid <= 1'b0;
        while (tracker.expected_events.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: delimited_frame_assembler.f
hdl/dfa_pkg.sv
hdl/dfa_frame.sv
hdl/dfa_burst.sv
hdl/delimited_frame_assembler.sv
test/tb_top.sv
